### rtl/rwcp_pkg.sv
package rwcp_pkg;

  // width of the running byte position
  localparam int unsigned POS_W = 32;

  localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
  localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
  localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
  localparam logic [31:0] TAG_DATA = 32'h6174_6164;

  localparam logic [31:0] FMT_BODY_LEN = 32'd16;
  localparam logic [15:0] FMT_PCM      = 16'd1;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NOT_WAVE = 2'd1,
    ST_NOT_PCM  = 2'd2,
    ST_MISSING  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CK_OTHER = 2'd0,
    CK_FMT   = 2'd1,
    CK_DATA  = 2'd2
  } chunk_kind_t;

  typedef struct packed {
    logic [7:0] byte_in;
    logic       last;
  } item_t;

  typedef struct packed {
    status_t     status;
    logic [15:0] channel_count;
    logic [31:0] rate_hz;
    logic [15:0] sample_bits;
    logic [31:0] payload_offset;
    logic [31:0] payload_size;
  } result_t;

  // position clipped to the 32-bit offset field
  function automatic logic [31:0] sat_offset(input logic [POS_W-1:0] pos);
    logic [POS_W+31:0] wide;
    wide = (POS_W + 32)'(pos);
    if (wide > (POS_W + 32)'(32'hFFFF_FFFF)) begin
      return 32'hFFFF_FFFF;
    end
    return wide[31:0];
  endfunction

endpackage

### rtl/rwcp_ifs.sv
interface rwcp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;
  logic       last;

  modport source (output valid, output byte_in, output last, input ready);
  modport sink   (input valid, input byte_in, input last, output ready);
endinterface

interface rwcp_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [15:0] channel_count;
  logic [31:0] rate_hz;
  logic [15:0] sample_bits;
  logic [31:0] payload_offset;
  logic [31:0] payload_size;

  modport source (output valid, output status, output channel_count, output rate_hz,
                  output sample_bits, output payload_offset, output payload_size,
                  input ready);
  modport sink   (input valid, input status, input channel_count, input rate_hz,
                  input sample_bits, input payload_offset, input payload_size,
                  output ready);
endinterface

### rtl/riff_wave_chunk_parser.sv
// RIFF/WAVE header parser. Bytes of one file enter on in_ch, one request per
// byte, with last set on the final byte. Each file gives one result on out_ch:
// either an early error (bad RIFF/WAVE tag after byte 11, or a non-PCM format
// code at the end of the 16 fmt bytes) or, on the last byte, the verdict with
// channels, sample rate, bits per sample, data body offset and data size.
// After an early error the rest of the file up to last is dropped silently.
// Fields other than status read zero unless status is ok.
// A byte is registered on acceptance and processed when the pipeline advances;
// its result is registered in the result register that drives out_ch.
// Throughput: one byte per cycle while out_ch does not stall; the input
// register and the result register let a new byte enter while a finished
// result still waits on out_ch.
// When out_ch stalls with a result pending, the pipeline holds and in_ch.ready
// drops once the input register is also full.
// Reset (rst_n low, synchronous) empties both registers and returns the parser
// to the start of a file; the parser also rearms by itself after each last.
module riff_wave_chunk_parser (
  input  logic       clk,
  input  logic       rst_n,
  rwcp_in_if.sink    in_ch,
  rwcp_out_if.source out_ch
);

  logic              adv;
  logic              s1_valid;
  rwcp_pkg::item_t   s1_item;
  logic              step;
  logic              res_valid;
  rwcp_pkg::result_t res;

  rwcp_in_stage u_in_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .adv      (adv),
    .s1_valid (s1_valid),
    .s1_item  (s1_item)
  );

  assign step = s1_valid && adv;

  rwcp_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .item      (s1_item),
    .res_valid (res_valid),
    .res       (res)
  );

  rwcp_out_stage u_out_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .load_valid (step && res_valid),
    .load_res   (res),
    .adv        (adv),
    .out_ch     (out_ch)
  );

endmodule

### rtl/rwcp_in_stage.sv
module rwcp_in_stage (
  input  logic            clk,
  input  logic            rst_n,
  rwcp_in_if.sink         in_ch,
  input  logic            adv,
  output logic            s1_valid,
  output rwcp_pkg::item_t s1_item
);

  logic            valid_r;
  rwcp_pkg::item_t item_r;

  assign in_ch.ready = !valid_r || adv;
  assign s1_valid    = valid_r;
  assign s1_item     = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      item_r.byte_in <= in_ch.byte_in;
      item_r.last    <= in_ch.last;
    end
  end

endmodule

### rtl/rwcp_parser.sv
module rwcp_parser (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  rwcp_pkg::item_t   item,
  output logic              res_valid,
  output rwcp_pkg::result_t res
);

  typedef enum logic [4:0] {
    PH_HEADER     = 5'b00001,
    PH_CHUNK_HEAD = 5'b00010,
    PH_FMT_BODY   = 5'b00100,
    PH_SKIP       = 5'b01000,
    PH_ERROR_WAIT = 5'b10000
  } phase_t;

  localparam int unsigned PW = rwcp_pkg::POS_W;

  phase_t                phase_r, phase_nxt;
  logic [3:0]            fbi_r, fbi_nxt;
  logic [31:0]           shift_r, shift_nxt;
  rwcp_pkg::chunk_kind_t kind_r, kind_nxt;
  logic [31:0]           cur_size_r, cur_size_nxt;
  logic [32:0]           skip_r, skip_nxt;
  logic [PW-1:0]         pos_r, pos_nxt;
  logic                  fmt_seen_r, fmt_seen_nxt;
  logic [15:0]           fmt_code_r, fmt_code_nxt;
  logic [15:0]           chans_r, chans_nxt;
  logic [31:0]           rate_r, rate_nxt;
  logic [15:0]           bits_r, bits_nxt;
  logic [31:0]           offset_r, offset_nxt;
  logic [31:0]           size_r, size_nxt;
  logic                  err_r, err_nxt;
  logic                  tag_bad_r, tag_bad_nxt;

  logic                  early;
  rwcp_pkg::status_t     early_status;
  logic                  body_go;
  logic [32:0]           body_count;
  logic [32:0]           skip_dec;
  rwcp_pkg::status_t     fin_status;

  always_comb begin
    phase_nxt    = phase_r;
    fbi_nxt      = fbi_r;
    kind_nxt     = kind_r;
    cur_size_nxt = cur_size_r;
    skip_nxt     = skip_r;
    fmt_seen_nxt = fmt_seen_r;
    fmt_code_nxt = fmt_code_r;
    chans_nxt    = chans_r;
    rate_nxt     = rate_r;
    bits_nxt     = bits_r;
    offset_nxt   = offset_r;
    size_nxt     = size_r;
    err_nxt      = err_r;
    tag_bad_nxt  = tag_bad_r;
    early        = 1'b0;
    early_status = rwcp_pkg::ST_OK;
    body_go      = 1'b0;
    body_count   = '0;
    skip_dec     = skip_r;
    fin_status   = rwcp_pkg::ST_OK;

    pos_nxt   = (&pos_r) ? pos_r : pos_r + 1'b1;
    shift_nxt = {item.byte_in, shift_r[31:8]};

    unique case (phase_r)
      PH_HEADER: begin
        if (fbi_r == 4'd3 && shift_nxt != rwcp_pkg::TAG_RIFF) begin
          tag_bad_nxt = 1'b1;
        end
        if (fbi_r == 4'd11) begin
          fbi_nxt = '0;
          if (tag_bad_nxt || shift_nxt != rwcp_pkg::TAG_WAVE) begin
            early        = 1'b1;
            early_status = rwcp_pkg::ST_NOT_WAVE;
            err_nxt      = 1'b1;
            phase_nxt    = PH_ERROR_WAIT;
          end else begin
            phase_nxt = PH_CHUNK_HEAD;
          end
        end else begin
          fbi_nxt = fbi_r + 4'd1;
        end
      end
      PH_CHUNK_HEAD: begin
        if (fbi_r == 4'd3) begin
          if (shift_nxt == rwcp_pkg::TAG_FMT) begin
            kind_nxt = rwcp_pkg::CK_FMT;
          end else if (shift_nxt == rwcp_pkg::TAG_DATA) begin
            kind_nxt = rwcp_pkg::CK_DATA;
          end else begin
            kind_nxt = rwcp_pkg::CK_OTHER;
          end
        end
        if (fbi_r == 4'd7) begin
          cur_size_nxt = shift_nxt;
          if (kind_r == rwcp_pkg::CK_FMT) begin
            phase_nxt = PH_FMT_BODY;
            fbi_nxt   = '0;
          end else begin
            if (kind_r == rwcp_pkg::CK_DATA) begin
              offset_nxt = rwcp_pkg::sat_offset(pos_nxt);
              size_nxt   = shift_nxt;
            end
            // odd bodies carry a pad byte
            body_go    = 1'b1;
            body_count = {1'b0, shift_nxt} + 33'(shift_nxt[0]);
          end
        end else begin
          fbi_nxt = fbi_r + 4'd1;
        end
      end
      PH_FMT_BODY: begin
        case (fbi_r) inside
          4'd0, 4'd1: begin
            if (fbi_r[0]) fmt_code_nxt[15:8] = item.byte_in;
            else          fmt_code_nxt[7:0]  = item.byte_in;
          end
          4'd2, 4'd3: begin
            if (fbi_r[0]) chans_nxt[15:8] = item.byte_in;
            else          chans_nxt[7:0]  = item.byte_in;
          end
          4'd4, 4'd5, 4'd6, 4'd7: begin
            rate_nxt[8*fbi_r[1:0] +: 8] = item.byte_in;
          end
          4'd14, 4'd15: begin
            if (fbi_r[0]) bits_nxt[15:8] = item.byte_in;
            else          bits_nxt[7:0]  = item.byte_in;
          end
          default: ;
        endcase
        if (fbi_r == 4'd15) begin
          if (fmt_code_nxt != rwcp_pkg::FMT_PCM) begin
            early        = 1'b1;
            early_status = rwcp_pkg::ST_NOT_PCM;
            err_nxt      = 1'b1;
            phase_nxt    = PH_ERROR_WAIT;
            fbi_nxt      = '0;
          end else begin
            fmt_seen_nxt = 1'b1;
            body_go      = 1'b1;
            // short fmt sizes read 16 bytes anyway, with nothing left to skip
            body_count   = (cur_size_r < rwcp_pkg::FMT_BODY_LEN) ? '0
                           : {1'b0, cur_size_r} - {1'b0, rwcp_pkg::FMT_BODY_LEN};
          end
        end else begin
          fbi_nxt = fbi_r + 4'd1;
        end
      end
      PH_SKIP: begin
        if (skip_r != '0) begin
          skip_dec = skip_r - 33'd1;
        end
        skip_nxt = skip_dec;
        if (skip_dec == '0) begin
          phase_nxt = PH_CHUNK_HEAD;
          fbi_nxt   = '0;
        end
      end
      PH_ERROR_WAIT: ;
      default: ;
    endcase

    if (body_go) begin
      skip_nxt  = body_count;
      fbi_nxt   = '0;
      phase_nxt = (body_count == '0) ? PH_CHUNK_HEAD : PH_SKIP;
    end

    // end-of-file verdict, from the state after this byte
    if (phase_nxt == PH_HEADER) begin
      fin_status = rwcp_pkg::ST_NOT_WAVE;
    end else if (phase_nxt == PH_FMT_BODY || !fmt_seen_nxt || size_nxt == '0) begin
      fin_status = rwcp_pkg::ST_MISSING;
    end else begin
      fin_status = rwcp_pkg::ST_OK;
    end

    res_valid = early || (item.last && !err_nxt);
    res       = '0;
    res.status = early ? early_status : fin_status;
    if (!early && fin_status == rwcp_pkg::ST_OK) begin
      res.channel_count  = chans_nxt;
      res.rate_hz        = rate_nxt;
      res.sample_bits    = bits_nxt;
      res.payload_offset = offset_nxt;
      res.payload_size   = size_nxt;
    end

    // back to the reset state for the next file
    if (item.last) begin
      phase_nxt    = PH_HEADER;
      fbi_nxt      = '0;
      shift_nxt    = '0;
      kind_nxt     = rwcp_pkg::CK_OTHER;
      cur_size_nxt = '0;
      skip_nxt     = '0;
      pos_nxt      = '0;
      fmt_seen_nxt = 1'b0;
      fmt_code_nxt = '0;
      chans_nxt    = '0;
      rate_nxt     = '0;
      bits_nxt     = '0;
      offset_nxt   = '0;
      size_nxt     = '0;
      err_nxt      = 1'b0;
      tag_bad_nxt  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_HEADER;
      fbi_r      <= '0;
      shift_r    <= '0;
      kind_r     <= rwcp_pkg::CK_OTHER;
      cur_size_r <= '0;
      skip_r     <= '0;
      pos_r      <= '0;
      fmt_seen_r <= 1'b0;
      fmt_code_r <= '0;
      chans_r    <= '0;
      rate_r     <= '0;
      bits_r     <= '0;
      offset_r   <= '0;
      size_r     <= '0;
      err_r      <= 1'b0;
      tag_bad_r  <= 1'b0;
    end else if (step) begin
      phase_r    <= phase_nxt;
      fbi_r      <= fbi_nxt;
      shift_r    <= shift_nxt;
      kind_r     <= kind_nxt;
      cur_size_r <= cur_size_nxt;
      skip_r     <= skip_nxt;
      pos_r      <= pos_nxt;
      fmt_seen_r <= fmt_seen_nxt;
      fmt_code_r <= fmt_code_nxt;
      chans_r    <= chans_nxt;
      rate_r     <= rate_nxt;
      bits_r     <= bits_nxt;
      offset_r   <= offset_nxt;
      size_r     <= size_nxt;
      err_r      <= err_nxt;
      tag_bad_r  <= tag_bad_nxt;
    end
  end

endmodule

### rtl/rwcp_out_stage.sv
module rwcp_out_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load_valid,
  input  rwcp_pkg::result_t load_res,
  output logic              adv,
  rwcp_out_if.source        out_ch
);

  logic              valid_r;
  rwcp_pkg::result_t res_r;

  // the stage moves when the result register is empty or being drained
  assign adv = !valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= load_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && load_valid) begin
      res_r <= load_res;
    end
  end

  assign out_ch.valid          = valid_r;
  assign out_ch.status         = res_r.status;
  assign out_ch.channel_count  = res_r.channel_count;
  assign out_ch.rate_hz        = res_r.rate_hz;
  assign out_ch.sample_bits    = res_r.sample_bits;
  assign out_ch.payload_offset = res_r.payload_offset;
  assign out_ch.payload_size   = res_r.payload_size;

endmodule
